FILE: hw/rtl/ptp_pkg.sv
// shared constants, types and register reset values for the point transform
`timescale 1ns / 1ps
`default_nettype none
package ptp_pkg;

  localparam int FRAC_BITS = 16;
  localparam int FX_W      = 32;
  localparam int CFG_W     = 64;
  localparam int NUM_REGS  = 8;
  localparam int CFG_IDX_W = 4;
  localparam int PROD_W    = 2 * FX_W;
  localparam int SUM_W     = PROD_W + 2;
  localparam int V_W       = SUM_W + 1 - FRAC_BITS;
  localparam int MAG_W     = V_W;
  localparam int A_W       = V_W + FRAC_BITS;
  localparam int REM_W     = MAG_W + 1;
  localparam int Q_W       = FX_W;
  localparam int N_CELLS   = Q_W;

  localparam logic [CFG_IDX_W-1:0] REG_X_XY = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_X_ZW = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_Y_XY = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_Y_ZW = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_Z_XY = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_Z_ZW = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] REG_O_XY = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] REG_O_ZW = CFG_IDX_W'(7);

  localparam logic [CFG_W-1:0] ONE_LO = CFG_W'(1) << FRAC_BITS;
  localparam logic [CFG_W-1:0] ONE_HI = CFG_W'(1) << (FRAC_BITS + FX_W);

  localparam logic [FX_W-1:0] FX_MAX = {1'b0, {(FX_W-1){1'b1}}};
  localparam logic [FX_W-1:0] FX_MIN = {1'b1, {(FX_W-1){1'b0}}};

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [Q_W-1:0]   abits;
    logic [Q_W-1:0]   quo;
    logic             neg;
    logic             ovf;
  } lane_t;

  typedef struct packed {
    lane_t [2:0]      lane;
    logic [MAG_W-1:0] den;
    logic             divided;
  } item_t;

  function automatic logic [CFG_W-1:0] reg_reset(input logic [CFG_IDX_W-1:0] idx);
    logic [CFG_W-1:0] val;
    case (idx)
      REG_X_XY: val = ONE_LO;
      REG_Y_XY: val = ONE_HI;
      REG_Z_ZW: val = ONE_LO;
      REG_O_ZW: val = ONE_HI;
      default:  val = '0;
    endcase
    return val;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/ptp_cell.sv
// one restoring divide cell: one quotient bit for each of the three lanes
`timescale 1ns / 1ps
`default_nettype none
module ptp_cell (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           up_vld,
  input  wire ptp_pkg::item_t up_item,
  output logic                up_take,
  input  wire logic           dn_take,
  output logic                vld,
  output ptp_pkg::item_t      item
);

  logic           vld_r;
  ptp_pkg::item_t item_r;
  ptp_pkg::item_t item_nxt;

  assign up_take = !vld_r || dn_take;
  assign vld     = vld_r;
  assign item    = item_r;

  always_comb begin
    logic [ptp_pkg::REM_W-1:0] t;
    logic                      qb;
    item_nxt = up_item;
    for (int l = 0; l < 3; l++) begin
      t  = {up_item.lane[l].rem[ptp_pkg::REM_W-2:0], up_item.lane[l].abits[ptp_pkg::Q_W-1]};
      qb = t >= {1'b0, up_item.den};
      item_nxt.lane[l].rem   = qb ? t - {1'b0, up_item.den} : t;
      item_nxt.lane[l].abits = {up_item.lane[l].abits[ptp_pkg::Q_W-2:0], 1'b0};
      item_nxt.lane[l].quo   = {up_item.lane[l].quo[ptp_pkg::Q_W-2:0], qb};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_take) begin
      vld_r <= up_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (up_take) begin
      item_r <= item_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/point_transform_perspective.sv
// top level: 4x4 homogeneous point transform with perspective divide
// Takes one point per cycle and delivers one result per cycle in steady state while
// nothing stalls. A transaction passes a capture stage, a stage of twelve 32x32
// multipliers, a sum stage, a divide setup stage, a row of 32 divide cells (one
// quotient bit each) and the output register. Every stage holds its item only while
// the stage after it is full and stalled, so gaps close up under backpressure.
// The user must write configuration with no transaction in flight (unenforced).
`timescale 1ns / 1ps
`default_nettype none
module point_transform_perspective (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_wr_en,
  input  wire logic [ptp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ptp_pkg::CFG_W-1:0]      cfg_wdata,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic signed [ptp_pkg::FX_W-1:0] in_pos_x,
  input  wire logic signed [ptp_pkg::FX_W-1:0] in_pos_y,
  input  wire logic signed [ptp_pkg::FX_W-1:0] in_pos_z,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic signed [ptp_pkg::FX_W-1:0]     out_x,
  output logic signed [ptp_pkg::FX_W-1:0]     out_y,
  output logic signed [ptp_pkg::FX_W-1:0]     out_z,
  output logic                                out_divided,
  output logic                                out_clamped
);

  logic [ptp_pkg::CFG_W-1:0] cfg_r [ptp_pkg::NUM_REGS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ptp_pkg::NUM_REGS; i++) begin
        cfg_r[i] <= ptp_pkg::reg_reset(ptp_pkg::CFG_IDX_W'(i));
      end
    end else if (cfg_wr_en && (cfg_index < ptp_pkg::CFG_IDX_W'(ptp_pkg::NUM_REGS))) begin
      cfg_r[cfg_index[2:0]] <= cfg_wdata;
    end
  end

  // stage control
  logic s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r;
  logic s1_en, s2_en, s3_en, s4_en;
  logic out_take;
  logic [ptp_pkg::N_CELLS:0] c_vld;
  logic [ptp_pkg::N_CELLS:0] c_take;
  ptp_pkg::item_t            c_item [ptp_pkg::N_CELLS+1];

  assign out_take = !out_valid || !out_stall;
  assign s4_en    = !s4_vld_r || c_take[0];
  assign s3_en    = !s3_vld_r || s4_en;
  assign s2_en    = !s2_vld_r || s3_en;
  assign s1_en    = !s1_vld_r || s2_en;
  assign in_stall = !s1_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      s4_vld_r  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_en) s1_vld_r <= in_valid;
      if (s2_en) s2_vld_r <= s1_vld_r;
      if (s3_en) s3_vld_r <= s2_vld_r;
      if (s4_en) s4_vld_r <= s3_vld_r;
      if (out_take) out_valid <= c_vld[ptp_pkg::N_CELLS];
    end
  end

  // capture
  logic signed [ptp_pkg::FX_W-1:0] pos_r [3];

  always_ff @(posedge clk) begin
    if (s1_en) begin
      pos_r[0] <= in_pos_x;
      pos_r[1] <= in_pos_y;
      pos_r[2] <= in_pos_z;
    end
  end

  // products
  logic signed [ptp_pkg::PROD_W-1:0] prod_nxt [4][3];
  logic signed [ptp_pkg::PROD_W-1:0] prod_r   [4][3];

  always_comb begin
    logic signed [ptp_pkg::FX_W-1:0] c;
    for (int o = 0; o < 4; o++) begin
      for (int i = 0; i < 3; i++) begin
        c = cfg_r[2 * i + (o >> 1)][ptp_pkg::FX_W * (o & 1) +: ptp_pkg::FX_W];
        prod_nxt[o][i] = pos_r[i] * c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_en) prod_r <= prod_nxt;
  end

  // column sums, floor-rounded, plus translation
  logic signed [ptp_pkg::V_W-1:0] v_nxt [4];
  logic signed [ptp_pkg::V_W-1:0] v_r   [4];

  always_comb begin
    logic signed [ptp_pkg::SUM_W-1:0] s;
    logic signed [ptp_pkg::FX_W-1:0]  off;
    for (int o = 0; o < 4; o++) begin
      s = ptp_pkg::SUM_W'(prod_r[o][0]) + ptp_pkg::SUM_W'(prod_r[o][1])
        + ptp_pkg::SUM_W'(prod_r[o][2]);
      off = cfg_r[6 + (o >> 1)][ptp_pkg::FX_W * (o & 1) +: ptp_pkg::FX_W];
      v_nxt[o] = ptp_pkg::V_W'(off)
               + ptp_pkg::V_W'($signed(s[ptp_pkg::SUM_W-1:ptp_pkg::FRAC_BITS]));
    end
  end

  always_ff @(posedge clk) begin
    if (s3_en) v_r <= v_nxt;
  end

  // divide setup
  ptp_pkg::item_t s4_nxt;
  ptp_pkg::item_t s4_r;

  always_comb begin
    logic                       div;
    logic                       wneg;
    logic                       vneg;
    logic [ptp_pkg::MAG_W-1:0]  wmag;
    logic [ptp_pkg::MAG_W-1:0]  mag;
    logic [ptp_pkg::A_W-1:0]    a;
    logic [ptp_pkg::REM_W-1:0]  r0;
    div  = v_r[3] != '0;
    wneg = v_r[3][ptp_pkg::V_W-1];
    wmag = wneg ? ptp_pkg::MAG_W'(-v_r[3]) : ptp_pkg::MAG_W'(v_r[3]);
    s4_nxt.divided = div;
    s4_nxt.den     = div ? wmag : ptp_pkg::MAG_W'(1);
    for (int l = 0; l < 3; l++) begin
      vneg = v_r[l][ptp_pkg::V_W-1];
      mag  = vneg ? ptp_pkg::MAG_W'(-v_r[l]) : ptp_pkg::MAG_W'(v_r[l]);
      a    = div ? {mag, {ptp_pkg::FRAC_BITS{1'b0}}} : ptp_pkg::A_W'(mag);
      r0   = ptp_pkg::REM_W'(a[ptp_pkg::A_W-1:ptp_pkg::Q_W]);
      s4_nxt.lane[l].rem   = r0;
      s4_nxt.lane[l].abits = a[ptp_pkg::Q_W-1:0];
      s4_nxt.lane[l].quo   = '0;
      s4_nxt.lane[l].neg   = div ? (vneg ^ wneg) : vneg;
      s4_nxt.lane[l].ovf   = r0 >= {1'b0, s4_nxt.den};
    end
  end

  always_ff @(posedge clk) begin
    if (s4_en) s4_r <= s4_nxt;
  end

  // divide cells
  assign c_vld[0]                 = s4_vld_r;
  assign c_item[0]                = s4_r;
  assign c_take[ptp_pkg::N_CELLS] = out_take;

  for (genvar g = 0; g < ptp_pkg::N_CELLS; g++) begin : g_cell
    ptp_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .up_vld  (c_vld[g]),
      .up_item (c_item[g]),
      .up_take (c_take[g]),
      .dn_take (c_take[g+1]),
      .vld     (c_vld[g+1]),
      .item    (c_item[g+1])
    );
  end

  // saturation and output register
  logic [ptp_pkg::FX_W-1:0] res_nxt [3];
  logic [2:0]               clamp_nxt;

  always_comb begin
    ptp_pkg::lane_t ln;
    for (int l = 0; l < 3; l++) begin
      ln = c_item[ptp_pkg::N_CELLS].lane[l];
      clamp_nxt[l] = 1'b0;
      if (ln.neg) begin
        if (ln.ovf || (ln.quo > ptp_pkg::FX_MIN)) begin
          res_nxt[l]   = ptp_pkg::FX_MIN;
          clamp_nxt[l] = 1'b1;
        end else begin
          res_nxt[l] = -ln.quo;
        end
      end else begin
        if (ln.ovf || ln.quo[ptp_pkg::Q_W-1]) begin
          res_nxt[l]   = ptp_pkg::FX_MAX;
          clamp_nxt[l] = 1'b1;
        end else begin
          res_nxt[l] = ln.quo;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_take) begin
      out_x       <= res_nxt[0];
      out_y       <= res_nxt[1];
      out_z       <= res_nxt[2];
      out_divided <= c_item[ptp_pkg::N_CELLS].divided;
      out_clamped <= |clamp_nxt;
    end
  end

endmodule
`default_nettype wire
